@@ src/npf_pkg.sv @@
package npf_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_RESULTS    = 63;
	localparam int THR_W          = 34;
	localparam int TYPE_W         = 8;
	localparam int ID_W           = 16;
	localparam int FIELD_W        = 16;
	localparam int NMATCH_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic                      start_set;
		logic [TYPE_W-1:0]         point_type;
		logic [ID_W-1:0]           point_id;
		logic signed [FIELD_W-1:0] x_coord;
		logic signed [FIELD_W-1:0] y_coord;
	} point_t;

	typedef struct packed {
		logic [TYPE_W-1:0] key_type;
		logic [ID_W-1:0]   key_id;
		logic [TYPE_W-1:0] partner_type;
		logic [ID_W-1:0]   partner_id;
		logic              overflow;
		logic              last_pair;
	} pair_t;

	// token that travels down the distance pipeline beside the data
	typedef struct packed {
		logic              valid;
		logic              is_end;
		logic [TYPE_W-1:0] st_type;
		logic [ID_W-1:0]   st_id;
	} tag_t;

endpackage

@@ src/npf_stream_if.sv @@
interface npf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/npf_cell.sv @@
module npf_cell #(
	parameter int COORD_BITS = npf_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic signed [COORD_BITS-1:0]  d_x,
	input  logic signed [COORD_BITS-1:0]  d_y,
	input  logic [npf_pkg::TYPE_W-1:0]    d_type,
	input  logic [npf_pkg::ID_W-1:0]      d_id,
	output logic signed [COORD_BITS-1:0]  q_x,
	output logic signed [COORD_BITS-1:0]  q_y,
	output logic [npf_pkg::TYPE_W-1:0]    q_type,
	output logic [npf_pkg::ID_W-1:0]      q_id
);
	import npf_pkg::*;

	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [TYPE_W-1:0]            type_q;
	logic [ID_W-1:0]              id_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			x_q    <= d_x;
			y_q    <= d_y;
			type_q <= d_type;
			id_q   <= d_id;
		end
	end

	assign q_x    = x_q;
	assign q_y    = y_q;
	assign q_type = type_q;
	assign q_id   = id_q;
endmodule

@@ src/npf_dist.sv @@
module npf_dist #(
	parameter int COORD_BITS = npf_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [npf_pkg::THR_W-1:0]     threshold,
	input  logic signed [COORD_BITS-1:0]  px,
	input  logic signed [COORD_BITS-1:0]  py,
	input  logic signed [COORD_BITS-1:0]  qx,
	input  logic signed [COORD_BITS-1:0]  qy,
	input  npf_pkg::tag_t                 tag_in,
	output npf_pkg::tag_t                 tag_out,
	output logic                          match
);
	import npf_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        adx, ady;
	logic [DIFF_W-1:0]        adx_s1, ady_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic [SUM_W-1:0]         sum;
	logic                     match_s3;
	tag_t                     tag_s1, tag_s2, tag_s3;

	assign dx  = DIFF_W'(px) - DIFF_W'(qx);
	assign dy  = DIFF_W'(py) - DIFF_W'(qy);
	assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	assign sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1   <= adx;
			ady_s1   <= ady;
			sqx_s2   <= SQ_W'(adx_s1) * SQ_W'(adx_s1);
			sqy_s2   <= SQ_W'(ady_s1) * SQ_W'(ady_s1);
			match_s3 <= CMP_W'(sum) <= CMP_W'(threshold);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign tag_out = tag_s3;
	assign match   = match_s3;
endmodule

@@ src/neighbor_pair_finder_top.sv @@
// Channel  Dir  Transfer when         Payload
// points   in   valid && ready        start_set, point_type, point_id, x_coord, y_coord
// pairs    out  valid && ready        key/partner type and id, overflow, last_pair
// cfg      in   cfg_we high           threshold_sq (34 bits)
//
// Between one input transfer and the next, the stored points rotate once round the chain
// of cells past the single distance unit, then one end step runs through the three
// pipeline stages before ready rises again.
// A new point is taken only when the previous one is done.
// Reset empties the set and clears the threshold; stored points need no clearing.
// A stalled pairs channel freezes the rotation and the distance pipeline together.
module neighbor_pair_finder_top #(
	parameter int MAX_POINTS = npf_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = npf_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	npf_stream_if.sink                points,
	npf_stream_if.source              pairs,
	input  logic                      cfg_we,
	input  logic [npf_pkg::THR_W-1:0] cfg_wdata
);
	import npf_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic [THR_W-1:0]             thr_q;
	logic [CNT_W-1:0]             count_q, scan_cnt_q, r_q, eff_cnt;
	logic                         ovf_q, ovf_next;
	logic                         busy_q, issuing_q;
	logic [NMATCH_W-1:0]          nmatch_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic [TYPE_W-1:0]            qtype_q;
	logic [ID_W-1:0]              qid_q;
	logic                         en, accept, shift, load_new, take;
	tag_t                         tag_in, tag_s3;
	logic                         match_s3;
	pair_t                        pend_q, out_q, new_pair, out_next;
	logic                         pend_v_q, out_v_q;

	logic signed [COORD_BITS-1:0] cx [MAX_POINTS];
	logic signed [COORD_BITS-1:0] cy [MAX_POINTS];
	logic [TYPE_W-1:0]            ct [MAX_POINTS];
	logic [ID_W-1:0]              ci [MAX_POINTS];

	assign en     = !out_v_q || pairs.ready;
	assign accept = points.valid && !busy_q;
	assign points.ready = !busy_q;
	assign pairs.valid  = out_v_q;
	assign pairs.data   = out_q;

	assign eff_cnt  = points.data.start_set ? '0 : count_q;
	assign ovf_next = (points.data.start_set ? 1'b0 : ovf_q) || (eff_cnt >= CNT_W'(MAX_POINTS));

	assign shift    = en && issuing_q && (r_q < CNT_W'(MAX_POINTS));
	// the new point drops in at the tail just as its slot wraps round
	assign load_new = (r_q == scan_cnt_q) && (scan_cnt_q < CNT_W'(MAX_POINTS));

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		logic signed [COORD_BITS-1:0] dx_i, dy_i;
		logic [TYPE_W-1:0]            dt_i;
		logic [ID_W-1:0]              di_i;
		if (i == MAX_POINTS - 1) begin : g_tail
			assign dx_i = load_new ? qx_q : cx[0];
			assign dy_i = load_new ? qy_q : cy[0];
			assign dt_i = load_new ? qtype_q : ct[0];
			assign di_i = load_new ? qid_q : ci[0];
		end else begin : g_body
			assign dx_i = cx[i+1];
			assign dy_i = cy[i+1];
			assign dt_i = ct[i+1];
			assign di_i = ci[i+1];
		end
		npf_cell #(.COORD_BITS(COORD_BITS)) u_cell (
			.clk    (clk),
			.shift  (shift),
			.d_x    (dx_i),
			.d_y    (dy_i),
			.d_type (dt_i),
			.d_id   (di_i),
			.q_x    (cx[i]),
			.q_y    (cy[i]),
			.q_type (ct[i]),
			.q_id   (ci[i])
		);
	end

	always_comb begin
		tag_in.valid   = issuing_q && ((r_q < scan_cnt_q) || (r_q == CNT_W'(MAX_POINTS)));
		tag_in.is_end  = r_q == CNT_W'(MAX_POINTS);
		tag_in.st_type = ct[0];
		tag_in.st_id   = ci[0];
	end

	npf_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.threshold (thr_q),
		.px        (cx[0]),
		.py        (cy[0]),
		.qx        (qx_q),
		.qy        (qy_q),
		.tag_in    (tag_in),
		.tag_out   (tag_s3),
		.match     (match_s3)
	);

	always_comb begin
		if (tag_s3.st_type > qtype_q) begin
			new_pair.key_type     = qtype_q;
			new_pair.key_id       = qid_q;
			new_pair.partner_type = tag_s3.st_type;
			new_pair.partner_id   = tag_s3.st_id;
		end else begin
			new_pair.key_type     = tag_s3.st_type;
			new_pair.key_id       = tag_s3.st_id;
			new_pair.partner_type = qtype_q;
			new_pair.partner_id   = qid_q;
		end
		new_pair.overflow  = ovf_q;
		new_pair.last_pair = 1'b0;
	end

	always_comb begin
		out_next           = pend_q;
		out_next.last_pair = tag_s3.is_end;
	end

	assign take = tag_s3.valid && !tag_s3.is_end && match_s3 &&
		(nmatch_q < NMATCH_W'(MAX_RESULTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q    <= COORD_BITS'(points.data.x_coord);
			qy_q    <= COORD_BITS'(points.data.y_coord);
			qtype_q <= points.data.point_type;
			qid_q   <= points.data.point_id;
		end
		if (en && take) begin
			pend_q <= new_pair;
		end
		if (en) begin
			// hold one pair back until it is known whether another follows
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_cnt_q <= '0;
			ovf_q      <= 1'b0;
			busy_q     <= 1'b0;
			issuing_q  <= 1'b0;
			r_q        <= '0;
			nmatch_q   <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				scan_cnt_q <= eff_cnt;
				ovf_q      <= ovf_next;
				count_q    <= (eff_cnt < CNT_W'(MAX_POINTS)) ? eff_cnt + 1'b1 : eff_cnt;
				busy_q     <= 1'b1;
				issuing_q  <= 1'b1;
				r_q        <= '0;
				nmatch_q   <= '0;
			end
			if (en) begin
				if (issuing_q) begin
					if (r_q == CNT_W'(MAX_POINTS)) begin
						issuing_q <= 1'b0;
					end
					r_q <= r_q + 1'b1;
				end
				out_v_q <= 1'b0;
				priority if (tag_s3.valid && tag_s3.is_end) begin
					out_v_q  <= pend_v_q;
					pend_v_q <= 1'b0;
					busy_q   <= 1'b0;
				end else if (take) begin
					out_v_q  <= pend_v_q;
					pend_v_q <= 1'b1;
					nmatch_q <= nmatch_q + 1'b1;
				end
			end
		end
	end
endmodule
